// File: rtl/core/ival_pkg.sv
// Shared constants and types for the interrupt vector allocator.
// No dependencies; imported by every module of the block.
package ival_pkg;

  localparam int VEC_CNT = 256;
  localparam int VEC_W   = $clog2(VEC_CNT);
  localparam int OWN_W   = 16;
  localparam int MAX_GRP = 32;
  localparam int PND_W   = $clog2(MAX_GRP);
  localparam int PCNT_W  = PND_W + 1;

  typedef struct packed {
    logic             re;
    logic [VEC_W-1:0] raddr;
    logic             we;
    logic [VEC_W-1:0] waddr;
    logic [OWN_W-1:0] wdata;
  } tbl_req_t;

  typedef struct packed {
    logic             re;
    logic [PND_W-1:0] raddr;
    logic             we;
    logic [PND_W-1:0] waddr;
    logic [VEC_W-1:0] wdata;
  } pnd_req_t;

endpackage

// File: rtl/core/ival_table.sv
// Owner table: one-port-write, one-port-read memory with registered read data.
// Per-entry valid flags are cleared at reset; an invalid entry reads as free.
// Depends on ival_pkg.
module ival_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  ival_pkg::tbl_req_t        req,
  output logic [ival_pkg::OWN_W-1:0] rdata
);
  import ival_pkg::*;

  logic [OWN_W-1:0]   mem [VEC_CNT];
  logic [VEC_CNT-1:0] vld_r;
  logic [OWN_W-1:0]   rd_q_r;
  logic               rd_v_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q_r <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rd_v_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_v_r <= vld_r[req.raddr];
      end
    end
  end

  assign rdata = rd_v_r ? rd_q_r : '0;

endmodule

// File: rtl/core/ival_pend.sv
// Pending group-release list: small memory with registered read data.
// Contents are undefined until written. Depends on ival_pkg.
module ival_pend (
  input  logic                      clk,
  input  ival_pkg::pnd_req_t        req,
  output logic [ival_pkg::VEC_W-1:0] rdata
);
  import ival_pkg::*;

  logic [VEC_W-1:0] mem [MAX_GRP];
  logic [VEC_W-1:0] rd_q_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_q_r <= mem[req.raddr];
    end
  end

  assign rdata = rd_q_r;

endmodule

// File: rtl/core/interrupt_vector_allocator.sv
// Interrupt vector allocator top level: sequencer, config registers, result regs.
// A request settled at entry answers from IDLE; otherwise each table entry is read,
// then checked (release, transfer, lookup: one entry; allocate, count: up to the range;
// group allocate checks each vector, then 1 result per cycle). Group release checks each
// held vector, then clears each. busy is high meanwhile; results cannot stall.
// Synchronous reset: table reads free, range 48..239, search start 48.
module interrupt_vector_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_req_type,
  input  logic [ival_pkg::OWN_W-1:0]  in_owner,
  input  logic [ival_pkg::OWN_W-1:0]  in_new_owner,
  input  logic [ival_pkg::VEC_W-1:0]  in_vector,
  input  logic [7:0]                  in_group_size,
  input  logic                        in_group_last,
  output logic                        out_valid,
  output logic                        out_status,
  output logic [ival_pkg::VEC_W-1:0]  out_vector_out,
  output logic [ival_pkg::OWN_W-1:0]  out_owner_out,
  output logic [ival_pkg::VEC_W:0]    out_free_count,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ival_pkg::*;

  localparam logic [2:0] REQ_ALLOC = 3'd0;
  localparam logic [2:0] REQ_GRP   = 3'd1;
  localparam logic [2:0] REQ_REL   = 3'd2;
  localparam logic [2:0] REQ_GREL  = 3'd3;
  localparam logic [2:0] REQ_XFER  = 3'd4;
  localparam logic [2:0] REQ_LOOK  = 3'd5;
  localparam logic [2:0] REQ_COUNT = 3'd6;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_AL_RD = 4'd1;
  localparam logic [3:0] S_AL_CK = 4'd2;
  localparam logic [3:0] S_GA_RD = 4'd3;
  localparam logic [3:0] S_GA_CK = 4'd4;
  localparam logic [3:0] S_GA_WR = 4'd5;
  localparam logic [3:0] S_RL_RD = 4'd6;
  localparam logic [3:0] S_RL_CK = 4'd7;
  localparam logic [3:0] S_CT_RD = 4'd8;
  localparam logic [3:0] S_CT_CK = 4'd9;
  localparam logic [3:0] S_GR_PA = 4'd10;
  localparam logic [3:0] S_GR_TA = 4'd11;
  localparam logic [3:0] S_GR_CK = 4'd12;
  localparam logic [3:0] S_GR_WA = 4'd13;
  localparam logic [3:0] S_GR_WR = 4'd14;

  localparam logic [VEC_W-1:0] FIRST_RST = VEC_W'(48);
  localparam logic [VEC_W-1:0] LAST_RST  = VEC_W'(239);

  logic [VEC_W-1:0]  first_r, last_r;
  logic [3:0]        st_r, st_nxt;
  logic [2:0]        req_r, req_nxt;
  logic [OWN_W-1:0]  own_r, own_nxt, nown_r, nown_nxt;
  logic [VEC_W-1:0]  cur_r, cur_nxt, ss_r, ss_nxt;
  logic [VEC_W:0]    rem_r, rem_nxt, base_r, base_nxt, cnt_r, cnt_nxt;
  logic [PCNT_W-1:0] gsz_r, gsz_nxt, idx_r, idx_nxt, pcnt_r, pcnt_nxt;
  logic              perr_r, perr_nxt;

  logic              ov_r, ov_nxt, os_r, os_nxt, ol_r, ol_nxt;
  logic [VEC_W-1:0]  ovec_r, ovec_nxt;
  logic [OWN_W-1:0]  oown_r, oown_nxt;
  logic [VEC_W:0]    ocnt_r, ocnt_nxt;

  tbl_req_t          treq;
  pnd_req_t          preq;
  logic [OWN_W-1:0]  tdata;
  logic [VEC_W-1:0]  pdata;

  logic              nonempty;
  logic [VEC_W:0]    n_rng;
  logic [VEC_W+1:0]  gbase, gend;
  logic [VEC_W:0]    gsz9;
  logic [VEC_W-1:0]  cur_inc, gaddr;
  logic [VEC_W+1:0]  nbase, nend, gtop;
  logic              pfull, ok0;

  ival_table u_table (.clk(clk), .rst_n(rst_n), .req(treq), .rdata(tdata));
  ival_pend  u_pend  (.clk(clk), .req(preq), .rdata(pdata));

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {24'd0, last_r} : {24'd0, first_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= FIRST_RST;
      last_r  <= LAST_RST;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        last_r <= pwdata[VEC_W-1:0];
      end else begin
        first_r <= pwdata[VEC_W-1:0];
      end
    end
  end

  function automatic logic inr(input logic [VEC_W-1:0] v, input logic [VEC_W-1:0] lo,
                               input logic [VEC_W-1:0] hi);
    inr = (lo <= hi) && (v >= lo) && (v <= hi);
  endfunction

  assign nonempty = first_r <= last_r;
  assign n_rng    = {1'b0, last_r} - {1'b0, first_r} + (VEC_W+1)'(1);
  assign gsz9     = {1'b0, in_group_size};
  assign gbase    = ({2'b0, first_r} + {2'b0, in_group_size} - (VEC_W+2)'(1))
                    & ~({2'b0, in_group_size} - (VEC_W+2)'(1));
  assign gend     = gbase + {2'b0, in_group_size} - (VEC_W+2)'(1);
  assign cur_inc  = (cur_r == last_r) ? first_r : cur_r + VEC_W'(1);
  assign gaddr    = base_r[VEC_W-1:0] + VEC_W'(idx_r);
  assign nbase    = {1'b0, base_r} + (VEC_W+2)'(gsz_r);
  assign nend     = nbase + (VEC_W+2)'(gsz_r) - (VEC_W+2)'(1);
  assign gtop     = {1'b0, base_r} + (VEC_W+2)'(gsz_r);
  assign pfull    = pcnt_r == PCNT_W'(MAX_GRP);
  assign ok0      = (in_owner != '0) && !perr_r && !pfull;

  always_comb begin
    st_nxt   = st_r;   req_nxt  = req_r;  own_nxt = own_r;  nown_nxt = nown_r;
    cur_nxt  = cur_r;  ss_nxt   = ss_r;   rem_nxt = rem_r;  base_nxt = base_r;
    cnt_nxt  = cnt_r;  gsz_nxt  = gsz_r;  idx_nxt = idx_r;  pcnt_nxt = pcnt_r;
    perr_nxt = perr_r;
    ov_nxt   = 1'b0;   os_nxt   = 1'b0;   ol_nxt  = 1'b1;
    ovec_nxt = '0;     oown_nxt = '0;     ocnt_nxt = '0;
    treq     = '0;
    preq     = '0;

    case (st_r)
      S_IDLE: begin
        if (start) begin
          req_nxt  = in_req_type;
          own_nxt  = in_owner;
          nown_nxt = in_new_owner;
          cur_nxt  = in_vector;
          case (in_req_type)
            REQ_ALLOC: begin
              if (in_owner == '0 || !nonempty) begin
                ov_nxt = 1'b1; os_nxt = 1'b1;
              end else begin
                cur_nxt = inr(ss_r, first_r, last_r) ? ss_r : first_r;
                rem_nxt = n_rng;
                st_nxt  = S_AL_RD;
              end
            end
            REQ_GRP: begin
              if (in_owner == '0 || !nonempty || in_group_size == '0 ||
                  in_group_size > 8'(MAX_GRP) ||
                  (in_group_size & (in_group_size - 8'd1)) != '0 ||
                  gsz9 > n_rng || gend > {2'b0, last_r}) begin
                ov_nxt = 1'b1; os_nxt = 1'b1;
              end else begin
                base_nxt = gbase[VEC_W:0];
                gsz_nxt  = in_group_size[PCNT_W-1:0];
                idx_nxt  = '0;
                st_nxt   = S_GA_RD;
              end
            end
            REQ_REL, REQ_XFER: begin
              if (in_owner == '0 || !inr(in_vector, first_r, last_r) ||
                  (in_req_type == REQ_XFER && in_new_owner == '0)) begin
                ov_nxt = 1'b1; os_nxt = 1'b1;
              end else begin
                st_nxt = S_RL_RD;
              end
            end
            REQ_LOOK: begin
              if (!inr(in_vector, first_r, last_r)) begin
                ov_nxt = 1'b1; ovec_nxt = in_vector;
              end else begin
                st_nxt = S_RL_RD;
              end
            end
            REQ_COUNT: begin
              if (!nonempty) begin
                ov_nxt = 1'b1;
              end else begin
                cur_nxt = first_r;
                cnt_nxt = '0;
                st_nxt  = S_CT_RD;
              end
            end
            REQ_GREL: begin
              if (!pfull) begin
                preq.we    = 1'b1;
                preq.waddr = pcnt_r[PND_W-1:0];
                preq.wdata = in_vector;
                pcnt_nxt   = pcnt_r + PCNT_W'(1);
              end else begin
                perr_nxt = 1'b1;
              end
              if (in_group_last) begin
                if (!ok0) begin
                  ov_nxt = 1'b1; os_nxt = 1'b1;
                  pcnt_nxt = '0; perr_nxt = 1'b0;
                end else begin
                  idx_nxt = '0;
                  st_nxt  = S_GR_PA;
                end
              end
            end
            default: begin
              ov_nxt = 1'b1; os_nxt = 1'b1;
            end
          endcase
        end
      end
      S_AL_RD: begin
        treq.re = 1'b1; treq.raddr = cur_r;
        st_nxt = S_AL_CK;
      end
      S_AL_CK: begin
        if (tdata == '0) begin
          treq.we = 1'b1; treq.waddr = cur_r; treq.wdata = own_r;
          ss_nxt = cur_inc;
          ov_nxt = 1'b1; ovec_nxt = cur_r;
          st_nxt = S_IDLE;
        end else if (rem_r == (VEC_W+1)'(1)) begin
          ov_nxt = 1'b1; os_nxt = 1'b1;
          st_nxt = S_IDLE;
        end else begin
          rem_nxt = rem_r - (VEC_W+1)'(1);
          cur_nxt = cur_inc;
          st_nxt  = S_AL_RD;
        end
      end
      S_GA_RD: begin
        treq.re = 1'b1; treq.raddr = gaddr;
        st_nxt = S_GA_CK;
      end
      S_GA_CK: begin
        if (tdata != '0) begin
          idx_nxt = '0;
          if (nend > {2'b0, last_r}) begin
            ov_nxt = 1'b1; os_nxt = 1'b1;
            st_nxt = S_IDLE;
          end else begin
            base_nxt = nbase[VEC_W:0];
            st_nxt   = S_GA_RD;
          end
        end else if (idx_r == gsz_r - PCNT_W'(1)) begin
          idx_nxt = '0;
          st_nxt  = S_GA_WR;
        end else begin
          idx_nxt = idx_r + PCNT_W'(1);
          st_nxt  = S_GA_RD;
        end
      end
      S_GA_WR: begin
        treq.we = 1'b1; treq.waddr = gaddr; treq.wdata = own_r;
        ov_nxt = 1'b1; ovec_nxt = gaddr;
        ol_nxt = idx_r == gsz_r - PCNT_W'(1);
        if (ol_nxt) begin
          ss_nxt = (gtop > {2'b0, last_r}) ? first_r : gtop[VEC_W-1:0];
          st_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + PCNT_W'(1);
        end
      end
      S_RL_RD: begin
        treq.re = 1'b1; treq.raddr = cur_r;
        st_nxt = S_RL_CK;
      end
      S_RL_CK: begin
        ov_nxt = 1'b1;
        st_nxt = S_IDLE;
        if (req_r == REQ_LOOK) begin
          ovec_nxt = cur_r; oown_nxt = tdata;
        end else if (tdata != own_r) begin
          os_nxt = 1'b1;
        end else begin
          treq.we = 1'b1; treq.waddr = cur_r;
          treq.wdata = (req_r == REQ_XFER) ? nown_r : '0;
        end
      end
      S_CT_RD: begin
        treq.re = 1'b1; treq.raddr = cur_r;
        st_nxt = S_CT_CK;
      end
      S_CT_CK: begin
        cnt_nxt = cnt_r + ((tdata == '0) ? (VEC_W+1)'(1) : '0);
        if (cur_r == last_r) begin
          ov_nxt = 1'b1; ocnt_nxt = cnt_nxt;
          st_nxt = S_IDLE;
        end else begin
          cur_nxt = cur_r + VEC_W'(1);
          st_nxt  = S_CT_RD;
        end
      end
      S_GR_PA: begin
        preq.re = 1'b1; preq.raddr = idx_r[PND_W-1:0];
        st_nxt = S_GR_TA;
      end
      S_GR_TA: begin
        treq.re = 1'b1; treq.raddr = pdata;
        st_nxt = S_GR_CK;
      end
      S_GR_CK: begin
        if (!inr(pdata, first_r, last_r) || tdata != own_r) begin
          ov_nxt = 1'b1; os_nxt = 1'b1;
          pcnt_nxt = '0; perr_nxt = 1'b0;
          st_nxt = S_IDLE;
        end else if (idx_r == pcnt_r - PCNT_W'(1)) begin
          idx_nxt = '0;
          st_nxt  = S_GR_WA;
        end else begin
          idx_nxt = idx_r + PCNT_W'(1);
          st_nxt  = S_GR_PA;
        end
      end
      S_GR_WA: begin
        preq.re = 1'b1; preq.raddr = idx_r[PND_W-1:0];
        st_nxt = S_GR_WR;
      end
      S_GR_WR: begin
        treq.we = 1'b1; treq.waddr = pdata; treq.wdata = '0;
        if (idx_r == pcnt_r - PCNT_W'(1)) begin
          ov_nxt = 1'b1;
          pcnt_nxt = '0; perr_nxt = 1'b0;
          st_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + PCNT_W'(1);
          st_nxt  = S_GR_WA;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_IDLE;
      ss_r   <= FIRST_RST;
      pcnt_r <= '0;
      perr_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      ss_r   <= ss_nxt;
      pcnt_r <= pcnt_nxt;
      perr_r <= perr_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;  own_r  <= own_nxt;  nown_r <= nown_nxt;
    cur_r  <= cur_nxt;  rem_r  <= rem_nxt;  base_r <= base_nxt;
    cnt_r  <= cnt_nxt;  gsz_r  <= gsz_nxt;  idx_r  <= idx_nxt;
    os_r   <= os_nxt;   ol_r   <= ol_nxt;   ovec_r <= ovec_nxt;
    oown_r <= oown_nxt; ocnt_r <= ocnt_nxt;
  end

  assign busy           = st_r != S_IDLE;
  assign out_valid      = ov_r;
  assign out_status     = os_r;
  assign out_vector_out = ovec_r;
  assign out_owner_out  = oown_r;
  assign out_free_count = ocnt_r;
  assign out_last       = ol_r;

  a_bad_req: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req_type == 3'd7 |=> out_valid && out_status)
    else $error("unknown request not rejected");

  a_grp_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && !out_status)
    else $error("group results not contiguous");

  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && out_vector_out == '0)
    else $error("rejection result malformed");

  a_pcnt: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= PCNT_W'(MAX_GRP))
    else $error("pending count overflow");

endmodule

// File: sim/interrupt_vector_allocator_tb.sv
// Self-checking testbench for interrupt_vector_allocator: APB range setup,
// directed and random requests, predicted results compared per transaction.
// Depends on ival_pkg and the interrupt_vector_allocator RTL.
`timescale 1ns / 100ps

module interrupt_vector_allocator_tb;
  import ival_pkg::*;

  localparam logic [2:0] RQ_ALLOC   = 3'd0;
  localparam logic [2:0] RQ_GALLOC  = 3'd1;
  localparam logic [2:0] RQ_REL     = 3'd2;
  localparam logic [2:0] RQ_GREL    = 3'd3;
  localparam logic [2:0] RQ_XFER    = 3'd4;
  localparam logic [2:0] RQ_LOOKUP  = 3'd5;
  localparam logic [2:0] RQ_COUNT   = 3'd6;
  localparam logic [2:0] RQ_UNKNOWN = 3'd7;
  localparam logic [2:0] REG_FIRST  = 3'd0;
  localparam logic [2:0] REG_LAST   = 3'd4;

  typedef struct packed {
    logic             status;
    logic [VEC_W-1:0] vec;
    logic [OWN_W-1:0] own;
    logic [VEC_W:0]   cnt;
    logic             last;
  } grant_t;

  logic clk = 1'b0, rst_n = 1'b0, start = 1'b0;
  logic busy;
  logic [2:0] in_req_type = '0;
  logic [OWN_W-1:0] in_owner = '0, in_new_owner = '0;
  logic [VEC_W-1:0] in_vector = '0;
  logic [7:0] in_group_size = '0;
  logic in_group_last = 1'b0;
  logic out_valid, out_status, out_last;
  logic [VEC_W-1:0] out_vector_out;
  logic [OWN_W-1:0] out_owner_out;
  logic [VEC_W:0] out_free_count;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  interrupt_vector_allocator dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the allocator state
  logic [OWN_W-1:0] owners [VEC_CNT];
  int unsigned rng_lo = 48, rng_hi = 239, next_fit = 48;
  logic [VEC_W-1:0] held [MAX_GRP];
  int unsigned held_cnt = 0;
  bit held_err = 0;
  grant_t grants_due[$];
  int errors = 0;
  bit gaps_on = 1;

  function automatic bit range_ok();
    return rng_lo <= rng_hi;
  endfunction

  function automatic bit in_rng(int unsigned v);
    return range_ok() && v >= rng_lo && v <= rng_hi;
  endfunction

  function automatic void push(bit st, int unsigned v, int unsigned o, int unsigned c, bit l);
    grant_t g;
    g.status = st; g.vec = VEC_W'(v); g.own = OWN_W'(o); g.cnt = (VEC_W+1)'(c); g.last = l;
    grants_due.push_back(g);
  endfunction

  function automatic void predict_grants(logic [2:0] rq, logic [OWN_W-1:0] o,
                                         logic [OWN_W-1:0] no, logic [VEC_W-1:0] v,
                                         logic [7:0] gs, bit gl);
    int unsigned n, st, x, base, c, i;
    bit ok;
    case (rq)
      RQ_ALLOC: begin
        if (o == 0 || !range_ok()) begin push(1, 0, 0, 0, 1); return; end
        n = rng_hi - rng_lo + 1;
        st = (next_fit >= rng_lo && next_fit <= rng_hi) ? next_fit : rng_lo;
        for (i = 0; i < n; i++) begin
          x = st + i;
          if (x > rng_hi) x -= n;
          if (owners[x] == 0) begin
            owners[x] = o;
            next_fit = (x == rng_hi) ? rng_lo : ((x + 1) & 8'hFF);
            push(0, x, 0, 0, 1);
            return;
          end
        end
        push(1, 0, 0, 0, 1);
      end
      RQ_GALLOC: begin
        if (o == 0 || !range_ok()) begin push(1, 0, 0, 0, 1); return; end
        n = rng_hi - rng_lo + 1;
        if (gs == 0 || gs > MAX_GRP || (gs & (gs - 1)) != 0 || gs > n) begin
          push(1, 0, 0, 0, 1); return;
        end
        for (base = (rng_lo + gs - 1) & ~(gs - 1); base + gs - 1 <= rng_hi; base += gs) begin
          ok = 1;
          for (i = 0; i < gs; i++) if (owners[base + i] != 0) ok = 0;
          if (ok) begin
            for (i = 0; i < gs; i++) begin
              owners[base + i] = o;
              push(0, base + i, 0, 0, i + 1 == gs);
            end
            next_fit = (base + gs > rng_hi) ? rng_lo : ((base + gs) & 8'hFF);
            return;
          end
        end
        push(1, 0, 0, 0, 1);
      end
      RQ_REL: begin
        if (o == 0 || !in_rng(v) || owners[v] != o) begin push(1, 0, 0, 0, 1); return; end
        owners[v] = 0;
        push(0, 0, 0, 0, 1);
      end
      RQ_GREL: begin
        if (held_cnt < MAX_GRP) held[held_cnt++] = v;
        else held_err = 1;
        if (!gl) return;
        ok = (o != 0) && !held_err;
        for (i = 0; ok && i < held_cnt; i++)
          if (!in_rng(held[i]) || owners[held[i]] != o) ok = 0;
        if (ok) for (i = 0; i < held_cnt; i++) owners[held[i]] = 0;
        held_cnt = 0;
        held_err = 0;
        push(!ok, 0, 0, 0, 1);
      end
      RQ_XFER: begin
        if (o == 0 || no == 0 || !in_rng(v) || owners[v] != o) begin
          push(1, 0, 0, 0, 1); return;
        end
        owners[v] = no;
        push(0, 0, 0, 0, 1);
      end
      RQ_LOOKUP: push(0, v, in_rng(v) ? owners[v] : 0, 0, 1);
      RQ_COUNT: begin
        c = 0;
        if (range_ok()) for (i = rng_lo; i <= rng_hi; i++) if (owners[i] == 0) c++;
        push(0, 0, 0, c, 1);
      end
      default: push(1, 0, 0, 0, 1);
    endcase
  endfunction

  task automatic idle_burst();
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  task automatic send_request(logic [2:0] rq, logic [OWN_W-1:0] o, logic [OWN_W-1:0] no,
                              logic [VEC_W-1:0] v, logic [7:0] gs, bit gl);
    idle_burst();
    in_req_type <= rq; in_owner <= o; in_new_owner <= no;
    in_vector <= v; in_group_size <= gs; in_group_last <= gl;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_grants(rq, o, no, v, gs, gl);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_range(logic [2:0] addr, logic [7:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= {24'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
    if (addr == REG_FIRST) rng_lo = val; else rng_hi = val;
  endtask

  task automatic set_range(int unsigned lo, int unsigned hi);
    drain();
    write_range(REG_FIRST, 8'(lo));
    write_range(REG_LAST, 8'(hi));
  endtask

  function automatic logic [OWN_W-1:0] pick_owner();
    return $urandom_range(0, 9) == 0 ? OWN_W'($urandom) : OWN_W'($urandom_range(1, 4));
  endfunction

  function automatic logic [VEC_W-1:0] pick_vec();
    return $urandom_range(0, 7) == 0 ? VEC_W'($urandom)
                                     : VEC_W'($urandom_range(rng_lo, rng_hi > rng_lo ? rng_hi : rng_lo));
  endfunction

  task automatic test_directed();
    send_request(RQ_COUNT, 0, 0, 0, 0, 0);
    send_request(RQ_ALLOC, 0, 0, 0, 0, 0);
    send_request(RQ_ALLOC, 16'hFFFF, 0, 0, 0, 0);
    send_request(RQ_ALLOC, 1, 0, 0, 0, 0);
    send_request(RQ_GALLOC, 2, 0, 0, 8'd32, 0);
    send_request(RQ_GALLOC, 2, 0, 0, 8'd3, 0);
    send_request(RQ_GALLOC, 2, 0, 0, 8'd0, 0);
    send_request(RQ_GALLOC, 2, 0, 0, 8'd64, 0);
    send_request(RQ_GALLOC, 2, 0, 0, 8'hFF, 0);
    send_request(RQ_GALLOC, 3, 0, 0, 8'd1, 0);
    send_request(RQ_LOOKUP, 0, 0, 8'd48, 0, 0);
    send_request(RQ_LOOKUP, 0, 0, 8'd255, 0, 0);
    send_request(RQ_LOOKUP, 0, 0, 8'd0, 0, 0);
    send_request(RQ_XFER, 16'hFFFF, 16'h8000, 8'd48, 0, 0);
    send_request(RQ_XFER, 16'h8000, 0, 8'd48, 0, 0);
    send_request(RQ_REL, 1, 0, 8'd48, 0, 0);
    send_request(RQ_REL, 16'h8000, 0, 8'd48, 0, 0);
    send_request(RQ_GREL, 2, 0, 8'd64, 0, 0);
    send_request(RQ_COUNT, 0, 0, 0, 0, 0);
    send_request(RQ_GREL, 2, 0, 8'd65, 0, 1);
    send_request(RQ_GREL, 0, 0, 8'd66, 0, 1);
    send_request(RQ_UNKNOWN, 0, 0, 0, 0, 0);
    send_request(RQ_COUNT, 0, 0, 0, 0, 0);
  endtask

  task automatic test_group_overflow();
    for (int i = 0; i < 33; i++) send_request(RQ_GREL, 2, 0, VEC_W'(70 + i), 0, i == 32);
    send_request(RQ_GALLOC, 5, 0, 0, 8'd4, 0);
    send_request(RQ_GREL, 5, 0, 8'd64, 0, 0);
    send_request(RQ_GREL, 5, 0, 8'd65, 0, 1);
    send_request(RQ_LOOKUP, 0, 0, 8'd64, 0, 0);
  endtask

  task automatic test_range_extremes();
    set_range(9, 8);
    send_request(RQ_ALLOC, 1, 0, 0, 0, 0);
    send_request(RQ_GALLOC, 1, 0, 0, 8'd1, 0);
    send_request(RQ_COUNT, 0, 0, 0, 0, 0);
    send_request(RQ_LOOKUP, 0, 0, 8'd9, 0, 0);
    set_range(255, 255);
    send_request(RQ_ALLOC, 1, 0, 0, 0, 0);
    send_request(RQ_ALLOC, 1, 0, 0, 0, 0);
    send_request(RQ_GALLOC, 1, 0, 0, 8'd2, 0);
    send_request(RQ_REL, 1, 0, 8'd255, 0, 0);
    set_range(0, 255);
    send_request(RQ_GALLOC, 7, 0, 0, 8'd32, 0);
    send_request(RQ_COUNT, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random(int unsigned items, bit with_gaps);
    int unsigned k;
    logic [OWN_W-1:0] o;
    gaps_on = with_gaps;
    for (int i = 0; i < items; i++) begin
      k = $urandom_range(0, 99);
      o = pick_owner();
      if (k < 22) send_request(RQ_ALLOC, o, 0, 0, 0, 0);
      else if (k < 34) send_request(RQ_GALLOC, o, 0, 0,
                                    $urandom_range(0, 9) == 0 ? 8'($urandom)
                                                              : 8'(1 << $urandom_range(0, 5)), 0);
      else if (k < 52) send_request(RQ_REL, o, 0, pick_vec(), 0, 0);
      else if (k < 64) begin
        for (int j = $urandom_range(0, 3); j > 0; j--) send_request(RQ_GREL, o, 0, pick_vec(), 0, 0);
        send_request(RQ_GREL, o, 0, pick_vec(), 0, 1);
      end
      else if (k < 74) send_request(RQ_XFER, o, pick_owner(), pick_vec(), 0, 0);
      else if (k < 86) send_request(RQ_LOOKUP, OWN_W'($urandom), OWN_W'($urandom), pick_vec(),
                                    0, 0);
      else if (k < 96) send_request(RQ_COUNT, OWN_W'($urandom), 0, VEC_W'($urandom),
                                    8'($urandom), 0);
      else send_request(3'($urandom_range(6, 7)), OWN_W'($urandom), OWN_W'($urandom),
                        VEC_W'($urandom), 8'($urandom), 1'($urandom_range(0, 1)));
      if (i % 40 == 39) drain();
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid) begin
      if (grants_due.size() == 0) begin
        $error("unexpected transaction");
        errors++;
      end else begin
        g = grants_due.pop_front();
        if (out_status !== g.status) begin
          $error("status exp %0d got %0d", g.status, out_status); errors++;
        end
        if (out_vector_out !== g.vec) begin
          $error("vector_out exp %0d got %0d", g.vec, out_vector_out); errors++;
        end
        if (out_owner_out !== g.own) begin
          $error("owner_out exp %0d got %0d", g.own, out_owner_out); errors++;
        end
        if (out_free_count !== g.cnt) begin
          $error("free_count exp %0d got %0d", g.cnt, out_free_count); errors++;
        end
        if (out_last !== g.last) begin
          $error("last exp %0d got %0d", g.last, out_last); errors++;
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    foreach (owners[i]) owners[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_group_overflow();
    test_range_extremes();
    set_range(16, 200);
    test_random(80, 1);
    set_range(48, 239);
    test_random(75, 1);
    set_range(0, 63);
    test_random(45, 0);
    drain();
    if (errors == 0 && grants_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/ival_pkg.sv
rtl/core/ival_table.sv
rtl/core/ival_pend.sv
rtl/core/interrupt_vector_allocator.sv
sim/interrupt_vector_allocator_tb.sv
